// ===== hw/rtl/sfp_pkg.sv =====
// types, constants and the crc-8 step shared by the serial frame parser
package sfp_pkg;

   localparam logic [7:0] SYNC_BYTE     = 8'h7E;
   localparam logic [7:0] TYPE_VELOCITY = 8'hA0;
   localparam logic [7:0] TYPE_PID      = 8'h0F;
   localparam logic [7:0] CRC_POLY      = 8'h31;
   localparam logic [7:0] CRC_INIT      = 8'hFF;
   localparam logic [7:0] CRC_MSB       = 8'h80;

   localparam logic [4:0] POS_IDLE     = 5'd0;
   localparam logic [4:0] POS_SYNC     = 5'd1;
   localparam logic [4:0] POS_DATA     = 5'd2;
   localparam logic [4:0] POS_LED      = 5'd10;
   localparam logic [4:0] POS_VEL_LAST = 5'd11;
   localparam logic [4:0] POS_PID_LAST = 5'd26;

   localparam logic [2:0] LAST_WORD_VEL = 3'd1;
   localparam logic [2:0] LAST_WORD_PID = 3'd5;
   localparam logic [2:0] LAST_WORD_BAD = 3'd0;

   localparam logic KIND_VEL = 1'b0;
   localparam logic KIND_PID = 1'b1;

   typedef struct packed {
      logic       en;
      logic       bank;
      logic [4:0] pos;
      logic [7:0] data;
   } sfp_wr_type;

   typedef struct packed {
      logic       start;
      logic       kind;
      logic       ok;
      logic [7:0] led;
      logic       bank;
   } sfp_job_type;

   typedef struct packed {
      logic        frame_kind;
      logic [2:0]  word_index;
      logic [31:0] word_value;
      logic [7:0]  led_byte;
      logic        crc_ok;
      logic        last;
   } sfp_result_type;

   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int i = 0; i < 8; i++) begin
         if ((c & CRC_MSB) != 8'h00) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== hw/rtl/sfp_if.sv =====
// valid/ready channel interfaces for received bytes and decoded words
interface sfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface sfp_rsp_if;
   logic        valid;
   logic        ready;
   logic        frame_kind;
   logic [2:0]  word_index;
   logic [31:0] word_value;
   logic [7:0]  led_byte;
   logic        crc_ok;
   logic        last;

   modport source (output valid, output frame_kind, output word_index, output word_value,
                   output led_byte, output crc_ok, output last, input ready);
   modport sink (input valid, input frame_kind, input word_index, input word_value,
                 input led_byte, input crc_ok, input last, output ready);
endinterface

// ===== hw/rtl/sfp_frame_store.sv =====
// two-bank frame word memory, result read-out sequencer and output queue
module sfp_frame_store import sfp_pkg::*; #(
   parameter int FRAME_BUFFER_BYTES = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  sfp_wr_type  wr,
   input  sfp_job_type job,
   output logic        job_busy,
   sfp_rsp_if.source   rsp_chan
);

   localparam int WORDS  = (FRAME_BUFFER_BYTES + 1) / 4;
   localparam int WIDX_W = $clog2(WORDS);

   logic [31:0] frame_mem_ff [2][WORDS];

   logic             job_active_ff, job_active_in;
   logic             job_kind_ff;
   logic             job_ok_ff;
   logic [7:0]       job_led_ff;
   logic             job_bank_ff;
   logic [2:0]       job_idx_ff, job_idx_in;
   logic [2:0]       job_last_ff;

   logic             rd_v_ff;
   logic [31:0]      rd_data_ff;
   sfp_result_type   rd_meta_ff, rd_meta_in;

   sfp_result_type   fifo_ff [2];
   sfp_result_type   push_entry;
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic [1:0]       occ;
   logic             pop;
   logic             issue;

   logic [4:0]        pos_m2;
   logic [WIDX_W-1:0] wr_widx;
   logic              wr_hit;

   // byte-lane write of incoming frame bytes
   assign pos_m2  = wr.pos - POS_DATA;
   assign wr_widx = WIDX_W'(pos_m2[4:2]);
   assign wr_hit  = wr.en && (int'(wr.pos) < FRAME_BUFFER_BYTES);

   always_ff @(posedge clock) begin
      if (wr_hit) begin
         frame_mem_ff[wr.bank][wr_widx][{pos_m2[1:0], 3'b000} +: 8] <= wr.data;
      end
      if (issue) begin
         rd_data_ff <= frame_mem_ff[job_bank_ff][WIDX_W'(job_idx_ff)];
      end
   end

   // read-out sequencer
   assign pop      = rsp_chan.valid && rsp_chan.ready;
   assign occ      = cnt_ff + 2'(rd_v_ff) - 2'(pop);
   assign issue    = job_active_ff && (occ < 2'd2);
   assign job_busy = job_active_ff;

   always_comb begin
      job_active_in = job_active_ff;
      job_idx_in    = job_idx_ff;
      if (job.start) begin
         job_active_in = 1'b1;
         job_idx_in    = 3'd0;
      end else if (issue) begin
         job_idx_in = job_idx_ff + 3'd1;
         if (job_idx_ff == job_last_ff) begin
            job_active_in = 1'b0;
         end
      end
   end

   always_comb begin
      rd_meta_in            = rd_meta_ff;
      rd_meta_in.frame_kind = job_kind_ff;
      rd_meta_in.word_index = job_idx_ff;
      rd_meta_in.word_value = '0;
      rd_meta_in.led_byte   = job_led_ff;
      rd_meta_in.crc_ok     = job_ok_ff;
      rd_meta_in.last       = (job_idx_ff == job_last_ff);
   end

   always_comb begin
      push_entry            = rd_meta_ff;
      push_entry.word_value = rd_meta_ff.crc_ok ? rd_data_ff : 32'h0;
   end

   // output queue
   always_comb begin
      cnt_in    = cnt_ff + 2'(rd_v_ff) - 2'(pop);
      wr_ptr_in = rd_v_ff ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_active_ff <= 1'b0;
         job_idx_ff    <= 3'd0;
         rd_v_ff       <= 1'b0;
         cnt_ff        <= 2'd0;
         wr_ptr_ff     <= 1'b0;
         rd_ptr_ff     <= 1'b0;
      end else begin
         job_active_ff <= job_active_in;
         job_idx_ff    <= job_idx_in;
         rd_v_ff       <= issue;
         cnt_ff        <= cnt_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job.start) begin
         job_kind_ff <= job.kind;
         job_ok_ff   <= job.ok;
         job_led_ff  <= job.led;
         job_bank_ff <= job.bank;
         if (!job.ok) begin
            job_last_ff <= LAST_WORD_BAD;
         end else if (job.kind == KIND_PID) begin
            job_last_ff <= LAST_WORD_PID;
         end else begin
            job_last_ff <= LAST_WORD_VEL;
         end
      end
      if (issue) begin
         rd_meta_ff <= rd_meta_in;
      end
      if (rd_v_ff) begin
         fifo_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign rsp_chan.valid      = (cnt_ff != 2'd0);
   assign rsp_chan.frame_kind = fifo_ff[rd_ptr_ff].frame_kind;
   assign rsp_chan.word_index = fifo_ff[rd_ptr_ff].word_index;
   assign rsp_chan.word_value = fifo_ff[rd_ptr_ff].word_value;
   assign rsp_chan.led_byte   = fifo_ff[rd_ptr_ff].led_byte;
   assign rsp_chan.crc_ok     = fifo_ff[rd_ptr_ff].crc_ok;
   assign rsp_chan.last       = fifo_ff[rd_ptr_ff].last;

   a_queue_space: assert property (@(posedge clock) disable iff (reset)
      (3'(cnt_ff) + 3'(rd_v_ff)) <= 3'd2)
      else $error("output queue overrun");

   a_bad_crc_result: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.crc_ok |->
         rsp_chan.last && (rsp_chan.word_value == 32'h0) && (rsp_chan.word_index == 3'd0))
      else $error("crc error result malformed");

   a_job_taken: assert property (@(posedge clock) disable iff (reset)
      job.start |=> job_active_ff && (job_idx_ff == 3'd0))
      else $error("read-out job not started");

endmodule

// ===== hw/rtl/serial_frame_parser_crc8.sv =====
// serial frame parser: takes one received byte per transfer and waits for sync byte 0x7e;
// the following type byte selects a velocity frame (two words, led byte, crc, 12 bytes) or a
// pid frame (six words and crc, 27 bytes), other types drop one more byte. a crc-8 (poly 0x31,
// init 0xff) over type and payload is checked against the final byte. a good frame yields one
// result per 32-bit little-endian word, a bad crc a single flagged result with a zero word.
// one byte is taken every cycle the input is ready; payload bytes land in a two-bank word memory,
// and after a frame's final byte its words are read out one per cycle while the output queue has
// room, each read word registered before it enters the queue. the input holds off only on the final
// byte of a frame while the words of the frame before are still being read from the memory.
module serial_frame_parser_crc8 import sfp_pkg::*; #(
   parameter int FRAME_BUFFER_BYTES = 32
) (
   input logic        clock,
   input logic        reset,
   sfp_req_if.sink    req_chan,
   sfp_rsp_if.source  rsp_chan
);

   logic [4:0]  pos_ff, pos_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  crc_ff, crc_in;
   logic [7:0]  led_ff, led_in;
   logic        bank_ff, bank_in;

   logic        acc;
   logic        finishing;
   logic        job_busy;
   logic [7:0]  b;
   sfp_wr_type  wr;
   sfp_job_type job;

   assign b         = req_chan.rx_byte;
   assign finishing = ((pos_ff == POS_VEL_LAST) && (type_ff == TYPE_VELOCITY)) ||
                      ((pos_ff == POS_PID_LAST) && (type_ff == TYPE_PID));
   assign req_chan.ready = !(finishing && job_busy);
   assign acc       = req_chan.valid && req_chan.ready;

   always_comb begin
      pos_in    = pos_ff;
      type_in   = type_ff;
      crc_in    = crc_ff;
      led_in    = led_ff;
      bank_in   = bank_ff;
      wr.en     = 1'b0;
      wr.bank   = bank_ff;
      wr.pos    = pos_ff;
      wr.data   = b;
      job.start = 1'b0;
      job.kind  = (type_ff == TYPE_PID) ? KIND_PID : KIND_VEL;
      job.ok    = (b == crc_ff);
      job.led   = (type_ff == TYPE_VELOCITY) ? led_ff : 8'h00;
      job.bank  = bank_ff;
      if (acc) begin
         if (pos_ff > POS_SYNC) begin
            wr.en = 1'b1;
            if (pos_ff == POS_LED) begin
               led_in = b;
            end
            if (finishing) begin
               job.start = 1'b1;
               bank_in   = ~bank_ff;
               pos_in    = POS_IDLE;
            end else if ((type_ff == TYPE_VELOCITY) || (type_ff == TYPE_PID)) begin
               pos_in = pos_ff + 5'd1;
               crc_in = crc8_update(crc_ff, b);
            end else begin
               pos_in = POS_IDLE;
            end
         end else if (pos_ff == POS_SYNC) begin
            pos_in  = POS_DATA;
            type_in = b;
            crc_in  = crc8_update(CRC_INIT, b);
         end
         if ((pos_in == POS_IDLE) && (b == SYNC_BYTE)) begin
            pos_in = POS_SYNC;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= POS_IDLE;
         type_ff <= 8'h00;
         crc_ff  <= CRC_INIT;
         bank_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         type_ff <= type_in;
         crc_ff  <= crc_in;
         bank_ff <= bank_in;
      end
   end

   always_ff @(posedge clock) begin
      led_ff <= led_in;
   end

   sfp_frame_store #(
      .FRAME_BUFFER_BYTES (FRAME_BUFFER_BYTES)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .wr       (wr),
      .job      (job),
      .job_busy (job_busy),
      .rsp_chan (rsp_chan)
   );

   a_type_follows_sync: assert property (@(posedge clock) disable iff (reset)
      acc && (pos_ff == POS_SYNC) |=> (pos_ff == POS_DATA) && (type_ff == $past(b)))
      else $error("type byte not taken after sync");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_PID_LAST)
      else $error("frame position out of range");

   a_no_job_overlap: assert property (@(posedge clock) disable iff (reset)
      job.start |-> !job_busy)
      else $error("frame finished while read-out still busy");

   a_idle_waits_sync: assert property (@(posedge clock) disable iff (reset)
      acc && (pos_ff == POS_IDLE) && (b != SYNC_BYTE) |=> (pos_ff == POS_IDLE))
      else $error("left idle without sync byte");

endmodule

// ===== bench/serial_frame_parser_crc8_test.sv =====
// self-checking bench for the serial frame parser: byte frames in, decoded words checked
module serial_frame_parser_crc8_test;
   import sfp_pkg::*;

   localparam int FRAME_BUFFER_BYTES = 32;
   localparam int RANDOM_BYTES = 280;
   localparam int IDLE_LIMIT = 2000;
   localparam int LONG_HOLD = 400;
   localparam int DRAIN_CYCLES = 16;
   localparam int MAX_REPORTS = 10;
   localparam int DIRECTED_ROWS = 27;

   typedef enum logic [1:0] {ROW_PLAIN, ROW_GOOD_CRC, ROW_BAD_CRC} row_mode_type;

   typedef struct packed {
      logic [7:0]     data;
      row_mode_type   mode;
      logic           typed;
      sfp_result_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   sfp_req_if req();
   sfp_rsp_if rsp();

   serial_frame_parser_crc8 #(.FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req),
      .rsp_chan (rsp)
   );

   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{8'h00, ROW_PLAIN, 1'b0, '0},
      '{8'h7E, ROW_PLAIN, 1'b0, '0},
      '{8'h33, ROW_PLAIN, 1'b0, '0},
      '{8'h7E, ROW_PLAIN, 1'b0, '0},
      '{8'hA0, ROW_PLAIN, 1'b0, '0},
      '{8'hFF, ROW_PLAIN, 1'b0, '0},
      '{8'hFF, ROW_PLAIN, 1'b0, '0},
      '{8'hFF, ROW_PLAIN, 1'b0, '0},
      '{8'hFF, ROW_PLAIN, 1'b0, '0},
      '{8'h00, ROW_PLAIN, 1'b0, '0},
      '{8'h00, ROW_PLAIN, 1'b0, '0},
      '{8'h00, ROW_PLAIN, 1'b0, '0},
      '{8'h00, ROW_PLAIN, 1'b0, '0},
      '{8'hFF, ROW_PLAIN, 1'b0, '0},
      '{8'h00, ROW_GOOD_CRC, 1'b0, '0},
      '{8'h7E, ROW_PLAIN, 1'b0, '0},
      '{8'hA0, ROW_PLAIN, 1'b0, '0},
      '{8'h7E, ROW_PLAIN, 1'b0, '0},
      '{8'h01, ROW_PLAIN, 1'b0, '0},
      '{8'h02, ROW_PLAIN, 1'b0, '0},
      '{8'h03, ROW_PLAIN, 1'b0, '0},
      '{8'h80, ROW_PLAIN, 1'b0, '0},
      '{8'h00, ROW_PLAIN, 1'b0, '0},
      '{8'h00, ROW_PLAIN, 1'b0, '0},
      '{8'h7F, ROW_PLAIN, 1'b0, '0},
      '{8'h00, ROW_PLAIN, 1'b0, '0},
      '{8'h00, ROW_BAD_CRC, 1'b1, '{KIND_VEL, LAST_WORD_BAD, 32'h0, 8'h00, 1'b0, 1'b1}}
   };

   // behavioural parser state
   logic [4:0]     parse_pos;
   logic [7:0]     parse_type;
   logic [7:0]     parse_crc;
   logic [7:0]     frame_mem [FRAME_BUFFER_BYTES];
   sfp_result_type frame_words[$];
   sfp_result_type pending_words[$];

   int word_mismatches = 0;
   int parsed_bytes = 0;
   int sent_bytes = 0;
   int rsp_transfers = 0;
   bit tx_idle_on = 1'b1;
   bit rx_idle_on = 1'b1;

   function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      repeat (8) c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      return c;
   endfunction

   function automatic logic [31:0] frame_word(input int w);
      int base;
      base = 2 + 4 * w;
      return {frame_mem[base + 3], frame_mem[base + 2], frame_mem[base + 1], frame_mem[base]};
   endfunction

   function automatic void close_frame(input logic kind, input logic [2:0] last_word,
                                       input logic [7:0] led, input logic [7:0] rx_crc);
      if (rx_crc != parse_crc) begin
         frame_words.push_back(sfp_result_type'{kind, LAST_WORD_BAD, 32'h0, led, 1'b0, 1'b1});
      end else begin
         for (int w = 0; w <= last_word; w++) begin
            frame_words.push_back(sfp_result_type'{kind, 3'(w), frame_word(w), led, 1'b1,
                                                   w == last_word});
         end
      end
   endfunction

   function automatic void parse_byte(input logic [7:0] b);
      logic [4:0] pos;
      pos = parse_pos;
      frame_words = {};
      if (pos != POS_IDLE || b == SYNC_BYTE) parsed_bytes++;
      if (pos > POS_SYNC) begin
         if (int'(pos) < FRAME_BUFFER_BYTES) frame_mem[pos] = b;
         if (parse_type == TYPE_VELOCITY && pos == POS_VEL_LAST) begin
            close_frame(KIND_VEL, LAST_WORD_VEL, frame_mem[POS_LED], b);
            pos = POS_IDLE;
         end else if (parse_type == TYPE_PID && pos == POS_PID_LAST) begin
            close_frame(KIND_PID, LAST_WORD_PID, 8'h00, b);
            pos = POS_IDLE;
         end else if (parse_type == TYPE_VELOCITY || parse_type == TYPE_PID) begin
            parse_crc = crc_step(parse_crc, b);
            pos = pos + 5'd1;
         end else begin
            pos = POS_IDLE;
         end
      end else if (pos == POS_SYNC) begin
         parse_type = b;
         parse_crc = crc_step(CRC_INIT, b);
         pos = POS_DATA;
      end
      if (pos == POS_IDLE && b == SYNC_BYTE) pos = POS_SYNC;
      parse_pos = pos;
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic typed, input sfp_result_type want);
      int gap;
      gap = tx_idle_on ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.rx_byte <= b;
      do @(posedge clock); while ((req.valid && req.ready) !== 1'b1);
      parse_byte(b);
      if (typed) pending_words.push_back(want);
      else foreach (frame_words[i]) pending_words.push_back(frame_words[i]);
      sent_bytes++;
      if (sent_bytes % 40 == 0) tx_idle_on = ($urandom_range(0, 3) != 0);
   endtask

   function automatic logic [7:0] payload_byte();
      case ($urandom_range(0, 15))
         0: return SYNC_BYTE;
         1: return 8'h00;
         2: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_frame(input logic [7:0] ftype, input logic corrupt);
      int payload;
      logic [7:0] tail;
      send_byte(SYNC_BYTE, 1'b0, '0);
      send_byte(ftype, 1'b0, '0);
      payload = (ftype == TYPE_PID) ? 24 : (ftype == TYPE_VELOCITY) ? 9 : 1;
      repeat (payload) send_byte(payload_byte(), 1'b0, '0);
      if (ftype == TYPE_VELOCITY || ftype == TYPE_PID) begin
         tail = parse_crc;
         if (corrupt) begin
            tail = parse_crc ^ 8'($urandom_range(1, 255));
            if ($urandom_range(0, 1) == 1 && parse_crc != SYNC_BYTE) tail = SYNC_BYTE;
         end
         send_byte(tail, 1'b0, '0);
      end
   endtask

   // result side: random stalls, one long hold-off, transfer checking
   initial begin
      int stall;
      sfp_result_type got;
      sfp_result_type exp;
      rsp.ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = rx_idle_on ? $urandom_range(0, 8) : 0;
         if (rsp_transfers == 40) stall = LONG_HOLD;
         if (stall > 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while ((rsp.valid && rsp.ready) !== 1'b1);
         got = '{rsp.frame_kind, rsp.word_index, rsp.word_value, rsp.led_byte, rsp.crc_ok,
                 rsp.last};
         rsp_transfers++;
         if (rsp_transfers % 25 == 0) rx_idle_on = ($urandom_range(0, 3) != 0);
         if (pending_words.size() == 0) begin
            word_mismatches++;
            if (word_mismatches <= MAX_REPORTS) begin
               $display("unexpected word: kind %0d index %0d value %h led %h ok %0d last %0d",
                        got.frame_kind, got.word_index, got.word_value, got.led_byte,
                        got.crc_ok, got.last);
            end
         end else begin
            exp = pending_words.pop_front();
            if (got !== exp) begin
               word_mismatches++;
               if (word_mismatches <= MAX_REPORTS) begin
                  $display("word mismatch: exp kind %0d idx %0d value %h led %h ok %0d last %0d",
                           exp.frame_kind, exp.word_index, exp.word_value, exp.led_byte,
                           exp.crc_ok, exp.last);
                  $display("               got kind %0d idx %0d value %h led %h ok %0d last %0d",
                           got.frame_kind, got.word_index, got.word_value, got.led_byte,
                           got.crc_ok, got.last);
               end
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   initial begin
      int quiet;
      quiet = 0;
      do @(posedge clock); while (reset);
      while (quiet < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req.valid && req.ready) === 1'b1 || (rsp.valid && rsp.ready) === 1'b1) quiet = 0;
         else quiet++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin
      int start;
      int pick;
      logic [7:0] b;
      bit drained;
      req.valid = 1'b0;
      req.rx_byte = 8'h00;
      parse_pos = POS_IDLE;
      parse_type = 8'h00;
      parse_crc = CRC_INIT;
      drained = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         case (directed_rows[i].mode)
            ROW_GOOD_CRC: b = parse_crc;
            ROW_BAD_CRC: b = parse_crc ^ 8'hFF;
            default: b = directed_rows[i].data;
         endcase
         send_byte(b, directed_rows[i].typed, directed_rows[i].want);
      end

      start = parsed_bytes;
      while (parsed_bytes - start < RANDOM_BYTES) begin
         if (!drained && parsed_bytes - start > RANDOM_BYTES / 2) begin
            req.valid <= 1'b0;
            do @(posedge clock); while (pending_words.size() != 0);
            drained = 1'b1;
         end
         pick = $urandom_range(0, 19);
         if (pick <= 8) begin
            send_frame(TYPE_VELOCITY, 1'b0);
         end else if (pick <= 13) begin
            send_frame(TYPE_PID, 1'b0);
         end else if (pick == 14) begin
            send_frame(TYPE_VELOCITY, 1'b1);
         end else if (pick == 15) begin
            send_frame(TYPE_PID, 1'b1);
         end else if (pick <= 17) begin
            do b = 8'($urandom); while (b == TYPE_VELOCITY || b == TYPE_PID);
            send_frame(b, 1'b0);
         end else if (pick == 18) begin
            repeat ($urandom_range(1, 4)) begin
               do b = 8'($urandom); while (b == SYNC_BYTE);
               send_byte(b, 1'b0, '0);
            end
         end else begin
            // truncated or garbled frame
            send_byte(SYNC_BYTE, 1'b0, '0);
            repeat ($urandom_range(0, 6)) send_byte(payload_byte(), 1'b0, '0);
         end
      end

      req.valid <= 1'b0;
      do @(posedge clock); while (pending_words.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_words.size() != 0) $display("%0d words never arrived", pending_words.size());
      if (word_mismatches == 0 && pending_words.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/sfp_pkg.sv
hw/rtl/sfp_if.sv
hw/rtl/sfp_frame_store.sv
hw/rtl/serial_frame_parser_crc8.sv
bench/serial_frame_parser_crc8_test.sv
